FILE: src/buffer_sorter_ascending_core_assert.svh
// Assertion macros used by the sorter top level.
`ifndef BUFFER_SORTER_ASCENDING_CORE_ASSERT_SVH
`define BUFFER_SORTER_ASCENDING_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorter check failed: same-cycle rule");

// Next-cycle implication, checked outside reset.
`define BSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorter check failed: next-cycle rule");

`endif

FILE: src/bsa_pkg.sv
package bsa_pkg;

    // Input request: one element of the run.
    typedef struct packed {
        logic signed [31:0] value;
        logic               last_in;
    } t_in_req;

    // Output request: one element of the sorted run.
    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               last_out;
        logic               overflow;
    } t_out_req;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_en;     // input request taken
        logic scan_start;  // clear scan state, begin a new min search
        logic scan_run;    // min search in progress
        logic out_take;    // output request taken
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_done;   // best candidate settles at this edge
        logic out_last;    // pending result is the final one of the run
    } t_dp_status;

endpackage

FILE: src/buffer_sorter_ascending_core.sv
// Ascending sorter for runs of up to MAX_ELEMENTS signed 32-bit values. Elements are
// taken one per cycle while loading, into a store with one write and one read port;
// elements arriving when the store is full are dropped and reported on the overflow
// bit of the final result. The request flagged last_in starts the sort: each result
// is found by a min search that reads all n stored elements through the one RAM read
// port, compares each registered read word against the best so far, then presents
// the result. Equal values all come out, in arrival order. No input is taken while a
// run is being sorted or delivered. The store needs no clearing after reset.
module buffer_sorter_ascending_core #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bsa_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bsa_pkg::t_out_req o_out_data
);
    import bsa_pkg::*;

    `include "buffer_sorter_ascending_core_assert.svh"

    t_dp_cmd    cmd;
    t_dp_status status;

    bsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last_in),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    bsa_datapath #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_status  (status),
        .i_in_data (i_in_data),
        .o_out_data(o_out_data)
    );

    // Input is held off while a result is pending
    `BSA_ASSERT_NOW(a_no_load_during_out, i_clk, i_rst_n, o_out_valid, o_in_stall)
    // Final result hands the block back to loading
    `BSA_ASSERT_NEXT(a_last_returns_to_load, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && o_out_data.last_out, !o_out_valid && !o_in_stall)
    // Last input starts a scan, never a result in the next cycle
    `BSA_ASSERT_NEXT(a_last_in_starts_scan, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && i_in_data.last_in, cmd.scan_run && !o_out_valid)

endmodule

FILE: src/bsa_ram.sv
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/bsa_ctrl.sv
module bsa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_last,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bsa_pkg::t_dp_cmd    o_cmd,
    input  bsa_pkg::t_dp_status i_status
);
    import bsa_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_take;
    logic   out_take;

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = (r_state == S_OUT);
    assign in_take     = i_in_valid && (r_state == S_LOAD);
    assign out_take    = o_out_valid && !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (in_take && i_in_last) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_take) begin
                    n_state = i_status.out_last ? S_LOAD : S_SCAN;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands to the datapath
    always_comb begin
        o_cmd.load_en    = in_take;
        o_cmd.out_take   = out_take;
        o_cmd.scan_run   = (r_state == S_SCAN);
        o_cmd.scan_start = (in_take && i_in_last) || (out_take && !i_status.out_last);
    end

endmodule

FILE: src/bsa_datapath.sv
module bsa_datapath #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsa_pkg::t_dp_cmd    i_cmd,
    output bsa_pkg::t_dp_status o_status,
    input  bsa_pkg::t_in_req    i_in_data,
    output bsa_pkg::t_out_req   o_out_data
);
    import bsa_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int KW = 32 + AW;

    // Run bookkeeping
    logic [CW-1:0] r_fill;
    logic          r_dropped;
    logic [CW-1:0] r_out_cnt;
    logic          full;
    logic          out_last;

    // Scan pipeline
    logic [CW-1:0] r_issue;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic          issuing;
    logic [31:0]   rd_data;

    // Search keys: value with sign bit flipped, then index as tiebreak
    logic [KW-1:0] r_best_key;
    logic          r_have_best;
    logic [KW-1:0] r_prev_key;
    logic          r_have_prev;
    logic [KW-1:0] cur_key;
    logic          better;

    assign full     = (r_fill == CW'(MAX_ELEMENTS));
    assign out_last = (CW'(r_out_cnt + CW'(1)) == r_fill);
    assign issuing  = i_cmd.scan_run && (r_issue != r_fill);

    bsa_ram #(
        .WIDTH(32),
        .DEPTH(MAX_ELEMENTS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load_en && !full),
        .i_waddr(r_fill[AW-1:0]),
        .i_wdata(i_in_data.value),
        .i_raddr(r_issue[AW-1:0]),
        .o_rdata(rd_data)
    );

    assign cur_key = {~rd_data[31], rd_data[30:0], r_rd_idx};
    assign better  = (!r_have_prev || (cur_key > r_prev_key)) &&
                     (!r_have_best || (cur_key < r_best_key));

    // Fill count, drop flag and result count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_dropped   <= 1'b0;
            r_out_cnt   <= '0;
            r_have_prev <= 1'b0;
        end else begin
            if (i_cmd.load_en) begin
                if (full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_fill <= CW'(r_fill + CW'(1));
                end
            end
            if (i_cmd.out_take) begin
                if (out_last) begin
                    r_fill      <= '0;
                    r_dropped   <= 1'b0;
                    r_out_cnt   <= '0;
                    r_have_prev <= 1'b0;
                end else begin
                    r_out_cnt   <= CW'(r_out_cnt + CW'(1));
                    r_have_prev <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_take) begin
            r_prev_key <= r_best_key;
        end
    end

    // Min search over the stored run, one read per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue     <= '0;
            r_rd_vld    <= 1'b0;
            r_have_best <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_issue     <= '0;
            r_rd_vld    <= 1'b0;
            r_have_best <= 1'b0;
        end else begin
            r_rd_vld <= issuing;
            if (issuing) begin
                r_issue <= CW'(r_issue + CW'(1));
            end
            if (r_rd_vld && better) begin
                r_have_best <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_issue[AW-1:0];
        if (r_rd_vld && better) begin
            r_best_key <= cur_key;
        end
    end

    // Last read of the scan lands in this cycle
    assign o_status.scan_done = i_cmd.scan_run && r_rd_vld && (r_issue == r_fill);
    assign o_status.out_last  = out_last;

    assign o_out_data.sorted_value = {~r_best_key[KW-1], r_best_key[KW-2:AW]};
    assign o_out_data.last_out     = out_last;
    assign o_out_data.overflow     = out_last && r_dropped;

endmodule

FILE: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bsa_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic     i_clk;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_stall;
    t_in_req  i_in_data   = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_out_req o_out_data;

    // Requests waiting to be sent, and sorted results still owed by the block
    t_in_req            pending_q[$];
    t_out_req           sorted_expect_q[$];

    // Mirror of the run currently being collected
    logic signed [31:0] run_vals[$];
    bit                 run_dropped = 1'b0;

    bit in_took        = 1'b0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int err_count      = 0;
    int quiet_cycles   = 0;

    buffer_sorter_ascending_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Store one element of the run; on the last one emit the run in ascending order
    task automatic predict_sort(input t_in_req req);
        logic signed [31:0] ordered[$];
        logic signed [31:0] held;
        t_out_req           res;
        int                 i;
        int                 pos;
        if (run_vals.size() < CAPACITY) begin
            run_vals.push_back(req.value);
        end else begin
            run_dropped = 1'b1;
        end
        if (req.last_in) begin
            ordered = run_vals;
            for (i = 1; i < ordered.size(); i++) begin
                held = ordered[i];
                pos  = i;
                while (pos > 0 && ordered[pos - 1] > held) begin
                    ordered[pos] = ordered[pos - 1];
                    pos--;
                end
                ordered[pos] = held;
            end
            for (i = 0; i < ordered.size(); i++) begin
                res.sorted_value = ordered[i];
                res.last_out     = (i == ordered.size() - 1);
                res.overflow     = res.last_out && run_dropped;
                sorted_expect_q.push_back(res);
            end
            run_vals.delete();
            run_dropped = 1'b0;
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        int near_zero;
        near_zero = $urandom_range(0, 6);
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3:    return near_zero - 3;   // small pool, forces equal values
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_elem(input logic signed [31:0] value, input bit last);
        t_in_req req;
        req.value   = value;
        req.last_in = last;
        pending_q.push_back(req);
    endfunction

    task automatic queue_run(input int run_len);
        int k;
        for (k = 0; k < run_len; k++) begin
            push_elem(pick_value(), k == run_len - 1);
        end
    endtask

    // Mostly short runs, now and then a medium one
    task automatic queue_random_runs(input int n_items);
        int left;
        int run_len;
        left = n_items;
        while (left > 0) begin
            run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20)
                                                  : $urandom_range(1, 8);
            if (run_len > left) begin
                run_len = left;
            end
            queue_run(run_len);
            left -= run_len;
        end
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || sorted_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Input driver: holds a stalled request, otherwise sends or idles at random
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!(i_in_valid && !in_took)) begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_q[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Monitor: predict on input handshakes, check on output handshakes
    always @(posedge i_clk) begin : monitor
        t_out_req want;
        bit       out_took;
        if (i_rst_n) begin
            in_took  = i_in_valid && !o_in_stall;
            out_took = o_out_valid && !i_out_stall;
            if (in_took) begin
                predict_sort(pending_q.pop_front());
            end
            if (out_took) begin
                if (sorted_expect_q.size() == 0) begin
                    err_count++;
                    $display("%0t: result with none expected: value %0d last %b ovf %b",
                             $time, o_out_data.sorted_value, o_out_data.last_out,
                             o_out_data.overflow);
                end else begin
                    want = sorted_expect_q.pop_front();
                    if (o_out_data.sorted_value !== want.sorted_value) begin
                        err_count++;
                        $display("%0t: sorted_value expected %0d got %0d", $time,
                                 want.sorted_value, o_out_data.sorted_value);
                    end
                    if (o_out_data.last_out !== want.last_out) begin
                        err_count++;
                        $display("%0t: last_out expected %b got %b", $time,
                                 want.last_out, o_out_data.last_out);
                    end
                    if (o_out_data.overflow !== want.overflow) begin
                        err_count++;
                        $display("%0t: overflow expected %b got %b", $time,
                                 want.overflow, o_out_data.overflow);
                    end
                end
            end
            // Watchdog on handshake activity
            if (in_took || out_took) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("buffer_sorter_ascending_core: mismatch");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single-element runs at both extremes
        push_elem(32'sh8000_0000, 1'b1);
        push_elem(32'sh7fff_ffff, 1'b1);
        // Mixed signs around zero with both extremes
        push_elem(32'sh7fff_ffff, 1'b0);
        push_elem(32'sh8000_0000, 1'b0);
        push_elem(32'sd0, 1'b0);
        push_elem(-32'sd1, 1'b0);
        push_elem(32'sd1, 1'b1);
        // Equal values must all come out
        push_elem(32'sd5, 1'b0);
        push_elem(32'sd5, 1'b0);
        push_elem(-32'sd5, 1'b0);
        push_elem(32'sd5, 1'b1);
        // Already ascending, then strictly descending
        push_elem(-32'sd3, 1'b0);
        push_elem(-32'sd2, 1'b0);
        push_elem(-32'sd1, 1'b1);
        push_elem(32'sd3, 1'b0);
        push_elem(32'sd2, 1'b0);
        push_elem(32'sd1, 1'b1);

        // No idling on either side
        queue_random_runs(10);
        wait_idle();

        // Sender mostly idle
        send_idle_pct  = 84;
        recv_stall_pct = 0;
        queue_random_runs(10);
        wait_idle();

        // Receiver mostly stalled; the store fills and the last request is dropped
        send_idle_pct  = 0;
        recv_stall_pct = 84;
        queue_run(CAPACITY + 1);
        wait_idle();

        // Both sides idle part of the time
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        queue_random_runs(10);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("buffer_sorter_ascending_core: match");
        end else begin
            $display("buffer_sorter_ascending_core: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/bsa_pkg.sv
src/bsa_ram.sv
src/bsa_ctrl.sv
src/bsa_datapath.sv
src/buffer_sorter_ascending_core.sv
dv/tb_top.sv
